FILE: rtl/ima_pkg.sv
// ----------------------------------------------------------------------------
// ima_pkg
// Shared types and constants of the integer matrix arithmetic block: field
// widths, operating modes, command and register codes, and transfer payloads.
// ----------------------------------------------------------------------------
package ima_pkg;

    localparam int DATA_W    = 32;
    localparam int IDX_W     = 3;
    localparam int DIM_REG_W = 4;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 3;

    // Largest matrix side; the index fields and dimension registers are sized for it.
    localparam int MAX_DIM   = 8;
    localparam int ADDR_W    = $clog2(MAX_DIM * MAX_DIM);

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_SUB   = 2'd1,
        MODE_MUL   = 2'd2,
        MODE_SCALE = 2'd3
    } mode_t;

    localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         col_index;
        logic signed [DATA_W-1:0] element_value;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]         out_row;
        logic [IDX_W-1:0]         out_col;
        logic signed [DATA_W-1:0] out_value;
        logic                     shape_error;
        logic                     last;
    } out_item_t;

    // One term issued to the multiply-accumulate unit
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } issue_t;

endpackage

FILE: rtl/ima_store.sv
// ----------------------------------------------------------------------------
// ima_store
// Element stores for matrices A and B: one write port shared by both,
// one registered read port on each.
// ----------------------------------------------------------------------------
module ima_store (
    input  logic                       clk,
    input  logic                       we_a,
    input  logic                       we_b,
    input  logic [ima_pkg::ADDR_W-1:0] wr_addr,
    input  logic [ima_pkg::DATA_W-1:0] wr_data,
    input  logic [ima_pkg::ADDR_W-1:0] rd_addr_a,
    input  logic [ima_pkg::ADDR_W-1:0] rd_addr_b,
    output logic [ima_pkg::DATA_W-1:0] rd_data_a,
    output logic [ima_pkg::DATA_W-1:0] rd_data_b
);
    import ima_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    logic [DATA_W-1:0] mem_a [DEPTH];
    logic [DATA_W-1:0] mem_b [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            mem_a[wr_addr] <= wr_data;
        end
        rd_data_a <= mem_a[rd_addr_a];
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
        begin
            mem_b[wr_addr] <= wr_data;
        end
        rd_data_b <= mem_b[rd_addr_b];
    end

endmodule

FILE: rtl/ima_mac.sv
// ----------------------------------------------------------------------------
// ima_mac
// Shared arithmetic unit: one add/subtract/multiply stage followed by an
// accumulator. Each issued term passes through read, operate and accumulate.
// ----------------------------------------------------------------------------
module ima_mac (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ima_pkg::mode_t             mode,
    input  logic [ima_pkg::DATA_W-1:0] scale,
    input  ima_pkg::issue_t            issue,
    input  logic [ima_pkg::DATA_W-1:0] a_data,
    input  logic [ima_pkg::DATA_W-1:0] b_data,
    output logic                       done,
    output logic [ima_pkg::DATA_W-1:0] acc
);
    import ima_pkg::*;

    issue_t            s1_reg;
    issue_t            s2_reg;
    logic              done_reg;
    logic [DATA_W-1:0] op_reg;
    logic [DATA_W-1:0] op_next;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] acc_next;
    logic [DATA_W-1:0] mul_b;
    logic [DATA_W-1:0] prod;

    // The low half of the product is the same for signed and unsigned operands.
    assign mul_b = (mode == MODE_SCALE) ? scale : b_data;
    assign prod  = a_data * mul_b;

    always_comb
    begin
        unique case (mode)
            MODE_ADD: op_next = a_data + b_data;
            MODE_SUB: op_next = a_data - b_data;
            default:  op_next = prod;
        endcase
    end

    assign acc_next = (s2_reg.first ? '0 : acc_reg) + op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= '0;
            s2_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_reg   <= issue;
            s2_reg   <= s1_reg;
            done_reg <= s2_reg.valid && s2_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_reg.valid)
        begin
            op_reg <= op_next;
        end
        if (s2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

FILE: rtl/ima_seq.sv
// ----------------------------------------------------------------------------
// ima_seq
// Sequencer: takes input transfers, writes loads into the stores, walks the
// result elements and their terms, and holds the output register.
// ----------------------------------------------------------------------------
module ima_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ima_pkg::in_item_t             in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ima_pkg::out_item_t            out_item,
    input  ima_pkg::mode_t                mode,
    input  logic [ima_pkg::DIM_REG_W-1:0] a_rows,
    input  logic [ima_pkg::DIM_REG_W-1:0] a_cols,
    input  logic [ima_pkg::DIM_REG_W-1:0] b_rows,
    input  logic [ima_pkg::DIM_REG_W-1:0] b_cols,
    output logic                          we_a,
    output logic                          we_b,
    output logic [ima_pkg::ADDR_W-1:0]    wr_addr,
    output logic [ima_pkg::DATA_W-1:0]    wr_data,
    output logic [ima_pkg::ADDR_W-1:0]    rd_addr_a,
    output logic [ima_pkg::ADDR_W-1:0]    rd_addr_b,
    output ima_pkg::issue_t               issue,
    input  logic                          mac_done,
    input  logic [ima_pkg::DATA_W-1:0]    mac_acc
);
    import ima_pkg::*;

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW = ADDR_W;
    localparam int CW = $clog2(MAX_DIM + 1);
    localparam int XW = CW + IDX_W;
    localparam int SW = DIM_REG_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_RUN,
        S_DRAIN,
        S_HOLD
    } state_t;

    state_t           state_reg;
    logic [IW-1:0]    row_reg;
    logic [IW-1:0]    col_reg;
    logic [IW-1:0]    k_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg;

    logic [CW-1:0]    ar;
    logic [CW-1:0]    ac;
    logic [CW-1:0]    br;
    logic [CW-1:0]    bc;
    logic [CW-1:0]    n_terms;
    logic [CW-1:0]    n_cols;
    logic             shape_ok;
    logic             accept;
    logic             out_free;
    logic             out_load;
    logic             last_k;
    logic             last_col;
    logic             last_row;
    logic             load_a_ok;
    logic             load_b_ok;

    // Zero reads as one, anything above MAX_DIM as MAX_DIM.
    function automatic logic [CW-1:0] sat_dim(input logic [DIM_REG_W-1:0] d);
        logic [CW-1:0] res;
        if (d == '0)
        begin
            res = CW'(1);
        end
        else if (SW'(d) > SW'(MAX_DIM))
        begin
            res = CW'(MAX_DIM);
        end
        else
        begin
            res = CW'(d);
        end
        return res;
    endfunction

    function automatic logic [AW-1:0] elem_addr(input logic [IW-1:0] r,
                                                input logic [IW-1:0] c);
        return AW'(r) * AW'(MAX_DIM) + AW'(c);
    endfunction

    assign ar = sat_dim(a_rows);
    assign ac = sat_dim(a_cols);
    assign br = sat_dim(b_rows);
    assign bc = sat_dim(b_cols);

    always_comb
    begin
        unique case (mode)
            MODE_ADD, MODE_SUB: shape_ok = (ar == br) && (ac == bc);
            MODE_MUL:           shape_ok = (ac == br);
            default:            shape_ok = 1'b1;
        endcase
    end

    assign n_terms  = (mode == MODE_MUL) ? ac : CW'(1);
    assign n_cols   = (mode == MODE_MUL) ? bc : ac;
    assign last_k   = (XW'(k_reg) + XW'(1)) == XW'(n_terms);
    assign last_col = (XW'(col_reg) + XW'(1)) == XW'(n_cols);
    assign last_row = (XW'(row_reg) + XW'(1)) == XW'(ar);

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // A new result enters the output register in the error and hold states.
    assign out_load = out_free && ((state_reg == S_ERR) || (state_reg == S_HOLD));

    // Loads outside the configured shape are dropped.
    assign load_a_ok = (XW'(in_item.row_index) < XW'(ar)) && (XW'(in_item.col_index) < XW'(ac));
    assign load_b_ok = (XW'(in_item.row_index) < XW'(br)) && (XW'(in_item.col_index) < XW'(bc));

    assign we_a    = accept && (in_item.command == CMD_LOAD_A) && load_a_ok;
    assign we_b    = accept && (in_item.command == CMD_LOAD_B) && load_b_ok;
    assign wr_addr = elem_addr(IW'(in_item.row_index), IW'(in_item.col_index));
    assign wr_data = in_item.element_value;

    assign rd_addr_a = (mode == MODE_MUL) ? elem_addr(row_reg, k_reg)
                                          : elem_addr(row_reg, col_reg);
    assign rd_addr_b = (mode == MODE_MUL) ? elem_addr(k_reg, col_reg)
                                          : elem_addr(row_reg, col_reg);

    assign issue.valid = (state_reg == S_RUN);
    assign issue.first = (k_reg == '0);
    assign issue.last  = last_k;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && (in_item.command == CMD_COMPUTE))
                    begin
                        row_reg   <= '0;
                        col_reg   <= '0;
                        k_reg     <= '0;
                        state_reg <= shape_ok ? S_RUN : S_ERR;
                    end
                end
                S_ERR:
                begin
                    if (out_free)
                    begin
                        out_item_reg.out_row     <= '0;
                        out_item_reg.out_col     <= '0;
                        out_item_reg.out_value   <= '0;
                        out_item_reg.shape_error <= 1'b1;
                        out_item_reg.last        <= 1'b1;
                        state_reg                <= S_IDLE;
                    end
                end
                S_RUN:
                begin
                    if (last_k)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        k_reg <= k_reg + IW'(1);
                    end
                end
                S_DRAIN:
                begin
                    if (mac_done)
                    begin
                        state_reg <= S_HOLD;
                    end
                end
                S_HOLD:
                begin
                    if (out_free)
                    begin
                        out_item_reg.out_row     <= IDX_W'(row_reg);
                        out_item_reg.out_col     <= IDX_W'(col_reg);
                        out_item_reg.out_value   <= mac_acc;
                        out_item_reg.shape_error <= 1'b0;
                        out_item_reg.last        <= last_row && last_col;
                        if (last_row && last_col)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            if (last_col)
                            begin
                                col_reg <= '0;
                                row_reg <= row_reg + IW'(1);
                            end
                            else
                            begin
                                col_reg <= col_reg + IW'(1);
                            end
                            state_reg <= S_RUN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: rtl/integer_matrix_arithmetic.sv
// ----------------------------------------------------------------------------
// integer_matrix_arithmetic
// Integer matrix unit: loads elements of A and B, then adds, subtracts or
// multiplies them or scales A, one result element per output transfer.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+---------------------------
//  cfg     | in        | cfg_write            | cfg_index, cfg_data
//  in      | in        | in_valid / in_ready  | in_item (command, element)
//  out     | out       | out_valid / out_ready| out_item (row, col, value)
//
// A load is written into its store as the transfer is accepted. A compute
// sums n terms per result element (n is a_cols for the product, else 1)
// through the registered store read and the shared multiply-accumulate unit.
// A shape error goes through the error state to offer its single result.
// Reset restores the default configuration and clears the control; the stores
// are not cleared. A stalled output holds the error or hold state until taken.
module integer_matrix_arithmetic (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [ima_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ima_pkg::DATA_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ima_pkg::in_item_t             in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ima_pkg::out_item_t            out_item
);
    import ima_pkg::*;

    localparam int AW = ADDR_W;

    mode_t                mode_reg;
    logic [DIM_REG_W-1:0] a_rows_reg;
    logic [DIM_REG_W-1:0] a_cols_reg;
    logic [DIM_REG_W-1:0] b_rows_reg;
    logic [DIM_REG_W-1:0] b_cols_reg;
    logic [DATA_W-1:0]    scale_reg;

    logic                 we_a;
    logic                 we_b;
    logic [AW-1:0]        wr_addr;
    logic [DATA_W-1:0]    wr_data;
    logic [AW-1:0]        rd_addr_a;
    logic [AW-1:0]        rd_addr_b;
    logic [DATA_W-1:0]    rd_data_a;
    logic [DATA_W-1:0]    rd_data_b;
    issue_t               issue;
    logic                 mac_done;
    logic [DATA_W-1:0]    mac_acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_ADD;
            a_rows_reg <= DIM_REG_W'(1);
            a_cols_reg <= DIM_REG_W'(1);
            b_rows_reg <= DIM_REG_W'(1);
            b_cols_reg <= DIM_REG_W'(1);
            scale_reg  <= DATA_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MODE:   mode_reg   <= mode_t'(cfg_data[1:0]);
                REG_A_ROWS: a_rows_reg <= cfg_data[DIM_REG_W-1:0];
                REG_A_COLS: a_cols_reg <= cfg_data[DIM_REG_W-1:0];
                REG_B_ROWS: b_rows_reg <= cfg_data[DIM_REG_W-1:0];
                REG_B_COLS: b_cols_reg <= cfg_data[DIM_REG_W-1:0];
                REG_SCALE:  scale_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    ima_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .mode      (mode_reg),
        .a_rows    (a_rows_reg),
        .a_cols    (a_cols_reg),
        .b_rows    (b_rows_reg),
        .b_cols    (b_cols_reg),
        .we_a      (we_a),
        .we_b      (we_b),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .issue     (issue),
        .mac_done  (mac_done),
        .mac_acc   (mac_acc)
    );

    ima_store u_store (
        .clk       (clk),
        .we_a      (we_a),
        .we_b      (we_b),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    ima_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .mode   (mode_reg),
        .scale  (scale_reg),
        .issue  (issue),
        .a_data (rd_data_a),
        .b_data (rd_data_b),
        .done   (mac_done),
        .acc    (mac_acc)
    );

endmodule

FILE: rtl/ima_check.sv
// ----------------------------------------------------------------------------
// ima_check
// Port-level checks of the integer matrix arithmetic block, bound to the top.
// ----------------------------------------------------------------------------
module ima_check (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  ima_pkg::in_item_t  in_item,
    input  logic               out_valid,
    input  logic               out_ready,
    input  ima_pkg::out_item_t out_item
);
    import ima_pkg::*;

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped before the transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_item))
        else $error("output payload changed while stalled");

    // An error result is always the only and final result of its compute.
    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.shape_error |->
            out_item.last && (out_item.out_value == '0)
            && (out_item.out_row == '0) && (out_item.out_col == '0))
        else $error("malformed shape error result");

    // A compute keeps the input closed while its results are produced.
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_item.command == CMD_COMPUTE) |=> !in_ready)
        else $error("input reopened straight after a compute transfer");

endmodule

bind integer_matrix_arithmetic ima_check u_ima_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
